// File: design/sdel_pkg.sv
package sdel_pkg;

  localparam int OPC_W = 3;
  localparam int VAL_W = 32;
  localparam int STS_W = 2;
  localparam int CNT_W = 5;

  localparam logic [OPC_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPC_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPC_W-1:0] OP_INSERT     = 3'd2;
  localparam logic [OPC_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OPC_W-1:0] OP_POP_BACK   = 3'd4;

  localparam logic [STS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic signed [VAL_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [STS_W-1:0]        status;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
  } out_rsp_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_REPORT
  } ctl_state_t;

  typedef struct packed {
    logic exec;
    logic load;
  } dp_cmd_t;

endpackage

// File: design/sdel_ctrl.sv
module sdel_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output sdel_pkg::dp_cmd_t cmd
);
  import sdel_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CTL_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      CTL_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = CTL_REPORT;
        end
      end
      CTL_REPORT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load  = 1'b1;
          state_nxt = CTL_IDLE;
        end
      end
      default: begin
        state_nxt = CTL_IDLE;
      end
    endcase
    out_valid_nxt = cmd.load | (out_valid_r & out_stall);
  end

  assign out_valid = out_valid_r;

endmodule

// File: design/sdel_dpath.sv
module sdel_dpath #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sdel_pkg::dp_cmd_t cmd,
  input  sdel_pkg::in_req_t in_req,
  output sdel_pkg::out_rsp_t out_rsp
);
  import sdel_pkg::*;

  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  logic signed [VAL_W-1:0] entries_r [CAPACITY];
  logic signed [VAL_W-1:0] entries_nxt [CAPACITY];
  logic [OCC_W-1:0]        occ_r, occ_nxt;
  logic [STS_W-1:0]        status_r, status_nxt;
  out_rsp_t                rsp_r, rsp_nxt;

  logic                    full, empty, is_push, is_pop;
  logic [CAPACITY-1:0]     take;
  logic [IDX_W-1:0]        back_idx;

  assign full     = (occ_r == OCC_W'(CAPACITY));
  assign empty    = (occ_r == '0);
  assign is_push  = (in_req.opcode == OP_PUSH_FRONT) || (in_req.opcode == OP_PUSH_BACK) ||
                    (in_req.opcode == OP_INSERT);
  assign is_pop   = (in_req.opcode == OP_POP_FRONT) || (in_req.opcode == OP_POP_BACK);
  assign back_idx = IDX_W'(occ_r - 1'b1);

  // mark cells at or beyond the insert point
  always_comb begin
    logic run;
    logic past;
    run = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      past = (OCC_W'(i) >= occ_r);
      run  = run | ((OCC_W'(i) < occ_r) && (entries_r[i] > in_req.value));
      case (in_req.opcode)
        OP_PUSH_FRONT: take[i] = 1'b1;
        OP_PUSH_BACK:  take[i] = past;
        default:       take[i] = run | past;
      endcase
    end
  end

  always_comb begin
    occ_nxt    = occ_r;
    status_nxt = status_r;
    for (int i = 0; i < CAPACITY; i++) begin
      entries_nxt[i] = entries_r[i];
    end
    if (cmd.exec) begin
      status_nxt = ST_DONE;
      if (is_push) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          occ_nxt = occ_r + 1'b1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (take[i]) begin
              if (i == 0) begin
                entries_nxt[i] = in_req.value;
              end else if (take[i-1]) begin
                entries_nxt[i] = entries_r[i-1];
              end else begin
                entries_nxt[i] = in_req.value;
              end
            end
          end
        end
      end else if (is_pop) begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          occ_nxt = occ_r - 1'b1;
          if (in_req.opcode == OP_POP_FRONT) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
              entries_nxt[i] = entries_r[i+1];
            end
          end
        end
      end
    end
  end

  always_comb begin
    rsp_nxt = rsp_r;
    if (cmd.load) begin
      rsp_nxt.status      = status_r;
      rsp_nxt.count       = CNT_W'(occ_r);
      rsp_nxt.front_value = empty ? '0 : entries_r[0];
      rsp_nxt.back_value  = empty ? '0 : entries_r[back_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rsp_r    <= rsp_nxt;
    for (int i = 0; i < CAPACITY; i++) begin
      entries_r[i] <= entries_nxt[i];
    end
  end

  assign out_rsp = rsp_r;

endmodule

// File: design/sorted_double_ended_list_core.sv
// Ordered double-ended list of up to CAPACITY signed 32-bit values.
// Input channel in_valid/in_stall/in_req carries an opcode and a value:
// push front, push back, ordered insert (before the first stored value
// strictly greater), pop front or pop back. Each request yields one
// response on out_valid/out_stall/out_rsp: status, count, front and back
// values (0 when empty). A pop on an empty list or a push on a full list
// leaves the list unchanged and is flagged in the status.
// Timing: a request updates the cell row in the cycle it is accepted; the
// controller then enters its report state and loads the response into the
// output register as soon as that register is empty or not stalled, which
// raises out_valid. A new request is taken only after that load.
// in_stall is high during the response-load cycle. A response waiting in
// the output register does not block the next request; a stalled response
// holds, and the following response waits behind it.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// response. No clearing pass is needed.
module sorted_double_ended_list_core #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sdel_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output sdel_pkg::out_rsp_t out_rsp
);
  import sdel_pkg::*;

  dp_cmd_t cmd;

  sdel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sdel_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous still in flight");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status == ST_EMPTY) |->
      (out_rsp.count == '0 && out_rsp.front_value == '0 && out_rsp.back_value == '0))
    else $error("empty status with nonzero contents");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status == ST_FULL) |-> (out_rsp.count == CNT_W'(CAPACITY)))
    else $error("full status with wrong count");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && out_valid) |-> !out_stall)
    else $error("response overwritten while stalled");

endmodule
